// File: sv/sbrs_pkg.sv
// Package: shared types and constants for the block request sequencer.
`default_nettype none
package sbrs_pkg;
  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  drive;
    logic [31:0] byte_offset;
    logic        is_write;
    logic        transport_ok;
    logic [7:0]  scsi_status;
    logic [3:0]  sns_key;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cdb_byte;
    logic [2:0]  target;
    logic        is_last;
    logic [1:0]  reply_status;
    logic [10:0] bytes_done;
  } rsp_t;

  localparam logic [1:0] CMD_NEW     = 2'd0;
  localparam logic [1:0] CMD_DONE    = 2'd1;
  localparam logic [1:0] CMD_SNSCOMP = 2'd2;

  localparam logic [2:0] REG_PART0 = 3'd0;
  localparam logic [2:0] REG_PART1 = 3'd1;
  localparam logic [2:0] REG_PART2 = 3'd2;
  localparam logic [2:0] REG_PART3 = 3'd3;
  localparam logic [2:0] REG_BPT   = 3'd4;
  localparam logic [2:0] REG_SPB   = 3'd5;
  localparam logic [2:0] REG_ILV   = 3'd6;
  localparam logic [2:0] REG_TGT   = 3'd7;

  localparam logic [7:0] OP_READ10  = 8'h28;
  localparam logic [7:0] OP_WRITE10 = 8'h2a;
  localparam logic [7:0] OP_SENSE   = 8'h03;
  localparam logic [7:0] SENSE_ALLOC = 8'd24;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_IO  = 2'd1;
  localparam logic [1:0] ST_END = 2'd2;

  // datapath commands
  typedef enum logic [2:0] {
    DP_NONE, DP_LOAD, DP_MOD1, DP_MUL, DP_MOD2, DP_PHYS, DP_SECT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic        mod_busy;
    logic        bad_part;
    logic        past_end;
    logic [31:0] sector;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: sv/sbrs_datapath.sv
// Datapath: partition lookup, iterative modulo, block to sector mapping.
`default_nettype none
module sbrs_datapath #(
  parameter int BLOCK_BYTES = 1024,
  parameter int PARTITIONS  = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sbrs_pkg::dp_cmd_t   cmd,
  input  wire sbrs_pkg::req_t      req,
  input  wire logic [255:0]        extents,
  input  wire logic [15:0]         blocks_per_track,
  input  wire logic [7:0]          sectors_per_block,
  input  wire logic [15:0]         interleave_map,
  output sbrs_pkg::dp_stat_t       stat
);
  localparam int SH = $clog2(BLOCK_BYTES);
  localparam int MW = 64;

  logic [31:0] block;
  logic [31:0] start;
  logic [3:0]  il;
  logic [15:0] bpt;
  logic [MW-1:0] rem;
  logic [MW-1:0] div_sh;
  logic [6:0]  cnt;
  logic        busy;
  logic [15:0] tb;
  logic [47:0] phys;
  logic [1:0]  drv;
  logic [19:0] prod;
  logic        bad_part;
  logic        past_end;
  logic [31:0] sector;

  logic [63:0] ext;
  logic [31:0] blk_in;
  assign drv    = req.drive[1:0];
  assign ext    = extents[drv*64 +: 64];
  assign blk_in = 32'(req.byte_offset >> SH);
  assign prod   = {4'd0, rem[15:0]} * {16'd0, il};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      unique case (cmd.op)
        sbrs_pkg::DP_LOAD: begin
          block <= blk_in;
          start <= ext[63:32];
          bpt   <= blocks_per_track;
          il    <= interleave_map[drv*4 +: 4];
          bad_part <= (req.drive >= 3'(PARTITIONS));
          past_end <= ({32'd0, blk_in} >= {32'd0, ext[31:0]});
        end
        sbrs_pkg::DP_MOD1: begin
          rem    <= {32'd0, block};
          div_sh <= {1'b0, bpt, 47'd0};
          cnt    <= 7'd47;
          busy   <= (bpt != 16'd0);
        end
        sbrs_pkg::DP_MUL: begin
          tb <= rem[15:0];
          rem <= {44'd0, prod};
        end
        sbrs_pkg::DP_MOD2: begin
          div_sh <= {1'b0, bpt, 47'd0};
          cnt    <= 7'd47;
          busy   <= 1'b1;
        end
        sbrs_pkg::DP_PHYS: begin
          if (bpt == 16'd0) phys <= {16'd0, block} + {16'd0, start};
          else phys <= {16'd0, block} - {32'd0, tb} + {32'd0, rem[15:0]}
                       + {16'd0, start};
        end
        sbrs_pkg::DP_SECT: begin
          sector <= 32'(phys[31:0] * {24'd0, sectors_per_block});
        end
        default: begin
          if (busy) begin
            if (rem >= div_sh) rem <= rem - div_sh;
            div_sh <= div_sh >> 1;
            cnt    <= cnt - 7'd1;
            if (cnt == 7'd0) busy <= 1'b0;
          end
        end
      endcase
    end
  end

  assign stat = '{mod_busy: busy, bad_part: bad_part, past_end: past_end,
                  sector: sector};
endmodule
`default_nettype wire

// File: sv/sbrs_ctrl.sv
// Controller: request sequencing, retry count and command byte output.
`default_nettype none
module sbrs_ctrl #(
  parameter int BLOCK_BYTES = 1024,
  parameter int MAX_TRIES   = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sbrs_pkg::req_t     req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sbrs_pkg::rsp_t          rsp,
  input  wire logic [2:0]         target_id,
  input  wire logic [7:0]         sectors_per_block,
  output sbrs_pkg::dp_cmd_t       dp_cmd,
  input  wire sbrs_pkg::dp_stat_t dp_stat
);
  localparam logic [10:0] OK_BYTES = (BLOCK_BYTES > 2047) ? 11'd2047 : 11'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CHECK, S_MOD1, S_WAIT1, S_MUL, S_MOD2, S_WAIT2,
    S_PHYS, S_SECT, S_EMIT, S_REPLY
  } state_t;

  typedef enum logic [1:0] { PH_IDLE, PH_CMD, PH_SENSE } phase_t;

  state_t      state;
  phase_t      phase;
  logic [2:0]  tries;
  logic        write_request;
  logic [7:0]  sector_count;
  logic        sense_cmd;
  logic [3:0]  idx;
  logic [1:0]  rep_st;
  logic        rep_ok;
  logic [2:0]  tries_inc;
  logic        accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign tries_inc = tries + 3'd1;

  always_comb begin
    dp_cmd.op = sbrs_pkg::DP_NONE;
    unique case (state)
      S_IDLE:  if (accept && req.cmd == sbrs_pkg::CMD_NEW) dp_cmd.op = sbrs_pkg::DP_LOAD;
      S_MOD1:  dp_cmd.op = sbrs_pkg::DP_MOD1;
      S_MUL:   dp_cmd.op = sbrs_pkg::DP_MUL;
      S_MOD2:  dp_cmd.op = sbrs_pkg::DP_MOD2;
      S_PHYS:  dp_cmd.op = sbrs_pkg::DP_PHYS;
      S_SECT:  dp_cmd.op = sbrs_pkg::DP_SECT;
      default: dp_cmd.op = sbrs_pkg::DP_NONE;
    endcase
  end

  logic [7:0] cbyte;
  always_comb begin
    cbyte = 8'd0;
    if (sense_cmd) begin
      case (idx)
        4'd0: cbyte = sbrs_pkg::OP_SENSE;
        4'd4: cbyte = sbrs_pkg::SENSE_ALLOC;
        default: cbyte = 8'd0;
      endcase
    end else begin
      case (idx)
        4'd0: cbyte = write_request ? sbrs_pkg::OP_WRITE10 : sbrs_pkg::OP_READ10;
        4'd2: cbyte = dp_stat.sector[31:24];
        4'd3: cbyte = dp_stat.sector[23:16];
        4'd4: cbyte = dp_stat.sector[15:8];
        4'd5: cbyte = dp_stat.sector[7:0];
        4'd8: cbyte = sector_count;
        default: cbyte = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_IDLE;
      tries         <= '0;
      write_request <= 1'b0;
      sector_count  <= '0;
      out_valid     <= 1'b0;
      sense_cmd     <= 1'b0;
      idx           <= '0;
      rep_st        <= '0;
      rep_ok        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(state inside {S_EMIT, S_REPLY})) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.cmd == sbrs_pkg::CMD_NEW) begin
              phase         <= PH_IDLE;
              write_request <= req.is_write;
              state         <= S_LOAD;
            end else if (req.cmd == sbrs_pkg::CMD_DONE && phase == PH_CMD) begin
              if (req.transport_ok && req.scsi_status == 8'd0) begin
                rep_st <= sbrs_pkg::ST_OK; rep_ok <= 1'b1; state <= S_REPLY;
              end else if (req.transport_ok && req.scsi_status == 8'd2) begin
                sense_cmd <= 1'b1; idx <= '0; state <= S_EMIT;
              end else begin
                tries <= tries_inc;
                if (tries_inc >= 3'(MAX_TRIES)) begin
                  rep_st <= sbrs_pkg::ST_IO; rep_ok <= 1'b0; state <= S_REPLY;
                end else begin
                  sense_cmd <= 1'b0; idx <= '0; state <= S_EMIT;
                end
              end
            end else if (req.cmd == sbrs_pkg::CMD_SNSCOMP && phase == PH_SENSE) begin
              if (req.transport_ok && req.scsi_status == 8'd0 && req.sns_key == 4'd1)
              begin
                rep_st <= sbrs_pkg::ST_OK; rep_ok <= 1'b1; state <= S_REPLY;
              end else begin
                tries <= tries_inc;
                if (tries_inc >= 3'(MAX_TRIES)) begin
                  rep_st <= sbrs_pkg::ST_IO; rep_ok <= 1'b0; state <= S_REPLY;
                end else begin
                  sense_cmd <= 1'b0; idx <= '0; state <= S_EMIT;
                end
              end
            end
          end
        end
        S_LOAD: state <= S_CHECK;
        S_CHECK: begin
          if (dp_stat.bad_part) begin
            rep_st <= sbrs_pkg::ST_IO; rep_ok <= 1'b0; state <= S_REPLY;
          end else if (dp_stat.past_end) begin
            rep_st <= sbrs_pkg::ST_END; rep_ok <= 1'b0; state <= S_REPLY;
          end else begin
            state <= S_MOD1;
          end
        end
        S_MOD1:  state <= S_WAIT1;
        S_WAIT1: if (!dp_stat.mod_busy) state <= S_MUL;
        S_MUL:   state <= S_MOD2;
        S_MOD2:  state <= S_WAIT2;
        S_WAIT2: if (!dp_stat.mod_busy) state <= S_PHYS;
        S_PHYS:  state <= S_SECT;
        S_SECT: begin
          sector_count <= sectors_per_block;
          tries        <= '0;
          sense_cmd    <= 1'b0;
          idx          <= '0;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            rsp.kind         <= 1'b0;
            rsp.cdb_byte     <= cbyte;
            rsp.target       <= target_id;
            rsp.reply_status <= sbrs_pkg::ST_OK;
            rsp.bytes_done   <= '0;
            idx              <= idx + 4'd1;
            if ((sense_cmd && idx == 4'd5) || (!sense_cmd && idx == 4'd9)) begin
              rsp.is_last <= 1'b1;
              phase       <= sense_cmd ? PH_SENSE : PH_CMD;
              state       <= S_IDLE;
            end else begin
              rsp.is_last <= 1'b0;
            end
          end
        end
        S_REPLY: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            rsp.kind         <= 1'b1;
            rsp.cdb_byte     <= '0;
            rsp.target       <= '0;
            rsp.is_last      <= 1'b1;
            rsp.reply_status <= rep_st;
            rsp.bytes_done   <= rep_ok ? OK_BYTES : 11'd0;
            phase            <= PH_IDLE;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepting while busy");
  a_tries: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (tries < 3'(MAX_TRIES)))
    else $error("tries overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(rsp)))
    else $error("result lost");
endmodule
`default_nettype wire

// File: sv/scsi_block_request_sequencer_top.sv
// Top level: configuration registers, controller and datapath.
// One request at a time; the input stays stalled until the block is idle again. A new
// request runs from acceptance to its last command byte through two 48-step restoring
// modulo passes by blocks_per_track (the first pass is skipped with blocks_per_track
// zero), the control states, then ten command bytes, one per cycle while the output is
// not stalled. A rejected request is answered with a reply. A completion is answered
// with a reply, a sense command or a retry. Output stalls add their length; the output
// register sets the byte pace.
`default_nettype none
module scsi_block_request_sequencer_top #(
  parameter int BLOCK_BYTES = 1024,
  parameter int PARTITIONS  = 4,
  parameter int MAX_TRIES   = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire sbrs_pkg::req_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output sbrs_pkg::rsp_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [63:0]     cfg_data
);
  logic [255:0] extents;
  logic [15:0]  blocks_per_track;
  logic [7:0]   sectors_per_block;
  logic [15:0]  interleave_map;
  logic [2:0]   target_id;
  sbrs_pkg::dp_cmd_t  dp_cmd;
  sbrs_pkg::dp_stat_t dp_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      extents           <= {64'd137138305792745, 64'd1997159824105, 64'd465, 64'd63395};
      blocks_per_track  <= 16'd155;
      sectors_per_block <= 8'd2;
      interleave_map    <= 16'd8465;
      target_id         <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbrs_pkg::REG_PART0: extents[63:0]    <= cfg_data;
        sbrs_pkg::REG_PART1: extents[127:64]  <= cfg_data;
        sbrs_pkg::REG_PART2: extents[191:128] <= cfg_data;
        sbrs_pkg::REG_PART3: extents[255:192] <= cfg_data;
        sbrs_pkg::REG_BPT:   blocks_per_track  <= cfg_data[15:0];
        sbrs_pkg::REG_SPB:   sectors_per_block <= cfg_data[7:0];
        sbrs_pkg::REG_ILV:   interleave_map    <= cfg_data[15:0];
        sbrs_pkg::REG_TGT:   target_id         <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  sbrs_ctrl #(.BLOCK_BYTES(BLOCK_BYTES), .MAX_TRIES(MAX_TRIES)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req(in_data), .out_valid, .out_stall,
    .rsp(out_data), .target_id, .sectors_per_block, .dp_cmd, .dp_stat
  );

  sbrs_datapath #(.BLOCK_BYTES(BLOCK_BYTES), .PARTITIONS(PARTITIONS)) u_dp (
    .clk, .rst, .cmd(dp_cmd), .req(in_data), .extents, .blocks_per_track,
    .sectors_per_block, .interleave_map, .stat(dp_stat)
  );
endmodule
`default_nettype wire
